// ===== src/assert_macros.svh =====
// Assertion helpers used by itf_emit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/itf_pkg.sv =====
//------------------------------------------------------------------------------
// itf_pkg
// Types and constants of the integer-to-text formatter.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itf_pkg;

    localparam int IN_W    = 96;
    localparam int OUT_W   = 80;
    localparam int DIGW    = 80;   // digit register: 20 BCD digits or 64/66 bits

    localparam logic [1:0] BASE_BIN = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_DEC = 2'd2;
    localparam logic [1:0] BASE_HEX = 2'd3;

    localparam logic [1:0] SMODE_PLUS  = 2'd1;
    localparam logic [1:0] SMODE_SPACE = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;

    typedef enum logic [1:0] {SG_NONE, SG_MINUS, SG_PLUS, SG_SPACE} sign_t;

    typedef enum logic [1:0] {CV_IDLE, CV_PREP, CV_DABBLE, CV_DONE} conv_state_t;

    typedef enum logic [1:0] {EM_IDLE, EM_SCAN, EM_SIZE, EM_EMIT} emit_state_t;

    typedef struct packed {
        logic [1:0] base;
        logic [7:0] min_width;
        logic [7:0] precision;
        logic       has_precision;
        logic       alt_prefix;
        logic       left_align;
        logic       zero_pad;
        logic       upper_case;
        sign_t      sign;
    } fmt_t;

    typedef struct packed {
        logic [DIGW-1:0] digits;
        logic [6:0]      slots;
        fmt_t            fmt;
    } xfer_t;

endpackage

`default_nettype wire

// ===== src/itf_conv.sv =====
//------------------------------------------------------------------------------
// itf_conv
// Operand capture, sign handling and bit-serial binary to BCD conversion.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itf_conv (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [itf_pkg::IN_W-1:0] s_tdata,
    output logic                        x_valid,
    input  wire logic                   x_ready,
    output itf_pkg::xfer_t              x_data
);
    import itf_pkg::*;

    conv_state_t      state_reg, state_next;
    logic [IN_W-1:0]  in_reg;
    logic [63:0]      src_reg, src_next;
    logic [DIGW-1:0]  bcd_reg, bcd_next;
    logic [5:0]       cnt_reg, cnt_next;
    sign_t            sign_reg, sign_next;

    logic [63:0] val, mask, mag;
    logic        top;
    logic [DIGW-1:0] adj;

    always_comb begin
        case (state_reg)
            CV_IDLE:   state_next = s_tvalid ? CV_PREP : CV_IDLE;
            CV_PREP:   state_next = (in_reg[68:67] == BASE_DEC) ? CV_DABBLE : CV_DONE;
            CV_DABBLE: state_next = (cnt_reg == 6'd63) ? CV_DONE : CV_DABBLE;
            CV_DONE:   state_next = x_ready ? CV_IDLE : CV_DONE;
            default:   state_next = CV_IDLE;
        endcase
    end

    always_comb begin
        val = in_reg[63:0];
        case (in_reg[65:64])
            2'd0:    begin mask = 64'hff;               top = val[7];  end
            2'd1:    begin mask = 64'hffff;             top = val[15]; end
            2'd2:    begin mask = 64'hffff_ffff;        top = val[31]; end
            default: begin mask = 64'hffff_ffff_ffff_ffff; top = val[63]; end
        endcase
        mag = val & mask;
        if (in_reg[66] && top) begin
            mag = ((~val) + 64'd1) & mask;
        end
        for (int i = 0; i < DIGW / 4; i++) begin
            adj[i*4 +: 4] = (bcd_reg[i*4 +: 4] >= 4'd5) ? bcd_reg[i*4 +: 4] + 4'd3
                                                        : bcd_reg[i*4 +: 4];
        end
        src_next  = src_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        sign_next = sign_reg;
        case (state_reg)
            CV_PREP: begin
                src_next = mag;
                bcd_next = '0;
                cnt_next = '0;
                if (!in_reg[66]) sign_next = SG_NONE;
                else if (top) sign_next = SG_MINUS;
                else if (in_reg[89:88] == SMODE_PLUS) sign_next = SG_PLUS;
                else if (in_reg[89:88] == SMODE_SPACE) sign_next = SG_SPACE;
                else sign_next = SG_NONE;
            end
            CV_DABBLE: begin
                bcd_next = {adj[DIGW-2:0], src_reg[63]};
                src_next = {src_reg[62:0], 1'b0};
                cnt_next = cnt_reg + 6'd1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CV_IDLE;
        end else begin
            state_reg <= state_next;
        end
        if (state_reg == CV_IDLE && s_tvalid) in_reg <= s_tdata;
        src_reg  <= src_next;
        bcd_reg  <= bcd_next;
        cnt_reg  <= cnt_next;
        sign_reg <= sign_next;
    end

    assign s_tready = (state_reg == CV_IDLE);
    assign x_valid  = (state_reg == CV_DONE);

    always_comb begin
        x_data.fmt.base          = in_reg[68:67];
        x_data.fmt.min_width     = in_reg[76:69];
        x_data.fmt.precision     = in_reg[84:77];
        x_data.fmt.has_precision = in_reg[85];
        x_data.fmt.alt_prefix    = in_reg[86];
        x_data.fmt.left_align    = in_reg[87];
        x_data.fmt.zero_pad      = in_reg[90];
        x_data.fmt.upper_case    = in_reg[91];
        x_data.fmt.sign          = sign_reg;
        case (in_reg[68:67])
            BASE_BIN: begin x_data.digits = {src_reg, 16'd0};       x_data.slots = 7'd64; end
            BASE_OCT: begin x_data.digits = {2'd0, src_reg, 14'd0}; x_data.slots = 7'd22; end
            BASE_DEC: begin x_data.digits = bcd_reg;                x_data.slots = 7'd20; end
            default:  begin x_data.digits = {src_reg, 16'd0};       x_data.slots = 7'd16; end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/itf_emit.sv =====
//------------------------------------------------------------------------------
// itf_emit
// Leading-zero scan, field sizing; one char per cycle out, except flushes.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module itf_emit #(
    parameter int MAX_FIELD_WIDTH  = 255,
    parameter int ZERO_FIELD_LIMIT = 80,
    parameter int CHARS_PER_RESULT = 8
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    x_valid,
    output logic                         x_ready,
    input  wire itf_pkg::xfer_t          x_data,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    output logic [itf_pkg::OUT_W-1:0]    m_tdata,
    output logic                         m_tlast
);
    import itf_pkg::*;

    emit_state_t     state_reg, state_next;
    fmt_t            fmt_reg, fmt_next;
    logic [DIGW-1:0] dig_reg, dig_next;
    logic [6:0]      slots_reg, slots_next;
    logic [7:0]      lead_reg, lead_next;
    logic            sgn_reg, sgn_next;
    logic [1:0]      pfx_len_reg, pfx_len_next;
    logic [1:0]      pfx_reg, pfx_next;
    logic [7:0]      pad_reg, pad_next;
    logic [7:0]      remain_reg, remain_next;
    logic [7:0]      total_reg, total_next;
    logic [63:0]     chunk_reg, chunk_next;
    logic [3:0]      cnt_reg, cnt_next;
    logic            m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] m_data_reg, m_data_next;
    logic            m_last_reg, m_last_next;

    logic [3:0]      dtop;
    logic [DIGW-1:0] dshift;
    logic [7:0]      dch, ch, wcap;
    logic [1:0]      plen;
    logic [9:0]      core, padw, cap, pad, size, spaces;
    logic            flush, slot_free;

    always_comb begin
        case (fmt_reg.base)
            BASE_BIN: begin dtop = {3'd0, dig_reg[DIGW-1]};   dshift = dig_reg << 1; end
            BASE_OCT: begin dtop = {1'b0, dig_reg[DIGW-1 -: 3]}; dshift = dig_reg << 3; end
            default:  begin dtop = dig_reg[DIGW-1 -: 4];      dshift = dig_reg << 4; end
        endcase
        if (dtop < 4'd10) dch = CH_ZERO + {4'd0, dtop};
        else dch = (fmt_reg.upper_case ? 8'h41 : 8'h61) + {4'd0, dtop} - 8'd10;
    end

    // field sizing
    always_comb begin
        wcap = (fmt_reg.min_width > 8'(MAX_FIELD_WIDTH)) ? 8'(MAX_FIELD_WIDTH)
                                                       : fmt_reg.min_width;
        if (!fmt_reg.alt_prefix) plen = 2'd0;
        else if (fmt_reg.base == BASE_OCT) plen = 2'd1;
        else if (fmt_reg.base == BASE_DEC) plen = 2'd0;
        else plen = 2'd2;
        core = {3'd0, slots_reg} + {9'd0, fmt_reg.sign != SG_NONE} + {8'd0, plen};
        if (fmt_reg.has_precision)
            padw = ({2'd0, fmt_reg.precision} > {3'd0, slots_reg})
                 ? {2'd0, fmt_reg.precision} - {3'd0, slots_reg} : 10'd0;
        else if (fmt_reg.zero_pad && !fmt_reg.left_align)
            padw = ({2'd0, wcap} > core) ? {2'd0, wcap} - core : 10'd0;
        else
            padw = 10'd0;
        cap    = 10'(ZERO_FIELD_LIMIT) - core;
        pad    = (padw > cap) ? cap : padw;
        size   = core + pad;
        spaces = ({2'd0, wcap} > size) ? {2'd0, wcap} - size : 10'd0;
    end

    always_comb begin
        slot_free = !m_valid_reg || m_tready;
        flush = (cnt_reg == 4'(CHARS_PER_RESULT)) || (remain_reg == 8'd0 && cnt_reg != 4'd0);
    end

    always_comb begin
        case (state_reg)
            EM_IDLE: state_next = x_valid ? EM_SCAN : EM_IDLE;
            EM_SCAN: state_next = (slots_reg > 7'd1 && dtop == 4'd0) ? EM_SCAN : EM_SIZE;
            EM_SIZE: state_next = EM_EMIT;
            EM_EMIT: state_next = (remain_reg == 8'd0 && cnt_reg == 4'd0) ? EM_IDLE : EM_EMIT;
            default: state_next = EM_IDLE;
        endcase
    end

    always_comb begin
        fmt_next     = fmt_reg;
        dig_next     = dig_reg;
        slots_next   = slots_reg;
        lead_next    = lead_reg;
        sgn_next     = sgn_reg;
        pfx_len_next = pfx_len_reg;
        pfx_next     = pfx_reg;
        pad_next     = pad_reg;
        remain_next  = remain_reg;
        total_next   = total_reg;
        chunk_next   = chunk_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        ch           = CH_SPACE;
        case (state_reg)
            EM_IDLE: begin
                if (x_valid) begin
                    fmt_next   = x_data.fmt;
                    dig_next   = x_data.digits;
                    slots_next = x_data.slots;
                end
            end
            EM_SCAN: begin
                if (slots_reg > 7'd1 && dtop == 4'd0) begin
                    dig_next   = dshift;
                    slots_next = slots_reg - 7'd1;
                end
            end
            EM_SIZE: begin
                lead_next    = fmt_reg.left_align ? 8'd0 : spaces[7:0];
                sgn_next     = (fmt_reg.sign != SG_NONE);
                pfx_len_next = plen;
                pfx_next     = plen;
                pad_next     = pad[7:0];
                remain_next  = 8'(size + spaces);
                total_next   = 8'(size + spaces);
                chunk_next   = '0;
                cnt_next     = '0;
            end
            EM_EMIT: begin
                if (flush) begin
                    if (slot_free) begin
                        m_valid_next = 1'b1;
                        m_last_next  = (remain_reg == 8'd0);
                        m_data_next  = {4'd0, (remain_reg == 8'd0) ? total_reg : 8'd0,
                                        cnt_reg, chunk_reg};
                        chunk_next   = '0;
                        cnt_next     = '0;
                    end
                end else if (remain_reg != 8'd0) begin
                    if (lead_reg != 8'd0) begin
                        ch = CH_SPACE;
                        lead_next = lead_reg - 8'd1;
                    end else if (sgn_reg) begin
                        case (fmt_reg.sign)
                            SG_MINUS: ch = CH_MINUS;
                            SG_PLUS:  ch = CH_PLUS;
                            default:  ch = CH_SPACE;
                        endcase
                        sgn_next = 1'b0;
                    end else if (pfx_reg != 2'd0) begin
                        if (pfx_reg == pfx_len_reg) ch = CH_ZERO;
                        else if (fmt_reg.base == BASE_BIN)
                            ch = fmt_reg.upper_case ? 8'h42 : 8'h62;
                        else
                            ch = fmt_reg.upper_case ? 8'h58 : 8'h78;
                        pfx_next = pfx_reg - 2'd1;
                    end else if (pad_reg != 8'd0) begin
                        ch = CH_ZERO;
                        pad_next = pad_reg - 8'd1;
                    end else if (slots_reg != 7'd0) begin
                        ch = dch;
                        dig_next   = dshift;
                        slots_next = slots_reg - 7'd1;
                    end else begin
                        ch = CH_SPACE;
                    end
                    chunk_next[cnt_reg[2:0]*8 +: 8] = ch;
                    cnt_next    = cnt_reg + 4'd1;
                    remain_next = remain_reg - 8'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= EM_IDLE;
            m_valid_reg <= 1'b0;
            remain_reg  <= '0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            remain_reg  <= remain_next;
            cnt_reg     <= cnt_next;
        end
        fmt_reg     <= fmt_next;
        dig_reg     <= dig_next;
        slots_reg   <= slots_next;
        lead_reg    <= lead_next;
        sgn_reg     <= sgn_next;
        pfx_len_reg <= pfx_len_next;
        pfx_reg     <= pfx_next;
        pad_reg     <= pad_next;
        total_reg   <= total_next;
        chunk_reg   <= chunk_next;
        m_data_reg  <= m_data_next;
        m_last_reg  <= m_last_next;
    end

    assign x_ready  = (state_reg == EM_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    `ASSERT_IMPLY(a_cnt_bound, 1'b1, cnt_reg <= 4'(CHARS_PER_RESULT))
    `ASSERT_IMPLY(a_out_nonempty, m_valid_reg, m_data_reg[67:64] != 4'd0)
    `ASSERT_NEXT(a_idle_drained, state_reg == EM_EMIT && state_next == EM_IDLE, cnt_reg == 4'd0)

endmodule

`default_nettype wire

// ===== src/integer_to_text_formatter_unit.sv =====
//------------------------------------------------------------------------------
// integer_to_text_formatter_unit
// printf-style integer conversion producing text in chunks.
//------------------------------------------------------------------------------
// Input stream s_*: one transfer carries one number and its format options.
// Output stream m_*: up to CHARS_PER_RESULT characters per transfer, first
// character in the lowest byte; tlast marks the final chunk, which also
// carries the total text length.
// Each stage holds one number at a time. After acceptance the options and
// sign are latched; a decimal value then goes through the bit-serial BCD
// conversion; the result is handed off; the scan strips leading zero digit
// slots (at most 63); the field is sized; then characters are emitted in
// turn, with a pause to send each chunk.
// s_tready is high only while the capture stage is empty; the next number is
// taken while the previous one is still being emitted.
// A stalled receiver holds the output register; the serializer waits once a
// chunk (full or final) is pending, with no loss.
// Reset (aresetn low, synchronous) returns all control to idle and drops any
// number in flight.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_to_text_formatter_unit #(
    parameter int MAX_FIELD_WIDTH  = 255,
    parameter int ZERO_FIELD_LIMIT = 80,
    parameter int CHARS_PER_RESULT = 8
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    // value[63:0] operand_size[65:64] is_signed[66] base_code[68:67]
    // min_width[76:69] precision[84:77] has_precision[85] alt_prefix[86]
    // left_align[87] sign_mode[89:88] zero_pad[90] upper_case[91]
    input  wire logic [itf_pkg::IN_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  wire logic                      m_tready,
    // chars[63:0] char_count[67:64] total_length[75:68]
    output logic [itf_pkg::OUT_W-1:0]      m_tdata,
    output logic                           m_tlast
);
    import itf_pkg::*;

    logic  x_valid, x_ready;
    xfer_t x_data;

    itf_conv u_conv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .x_valid  (x_valid),
        .x_ready  (x_ready),
        .x_data   (x_data)
    );

    itf_emit #(
        .MAX_FIELD_WIDTH  (MAX_FIELD_WIDTH),
        .ZERO_FIELD_LIMIT (ZERO_FIELD_LIMIT),
        .CHARS_PER_RESULT (CHARS_PER_RESULT)
    ) u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .x_valid  (x_valid),
        .x_ready  (x_ready),
        .x_data   (x_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
